>>> hdl/exact_double_square_top_macros.svh
// ----------------------------------------------------------------------------
// exact_double_square_top_macros
// assertion macros shared by the exact square block
// ----------------------------------------------------------------------------
`ifndef EXACT_DOUBLE_SQUARE_TOP_MACROS_SVH
`define EXACT_DOUBLE_SQUARE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define EDS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// types, constants and rounding helpers for the exact binary64 square
// ----------------------------------------------------------------------------
package eds_pkg;

    localparam int MagW = 106;
    localparam int ExpW = 14;

    localparam logic [63:0] F64_ZERO    = 64'h0000000000000000;
    localparam logic [63:0] F64_INF     = 64'h7FF0000000000000;
    localparam logic [63:0] F64_NEG_INF = 64'hFFF0000000000000;
    localparam logic [63:0] F64_QNAN    = 64'h7FF8000000000000;
    localparam logic [63:0] F64_QUIET   = 64'h0008000000000000;
    localparam logic [10:0] EXP_MAX     = 11'h7FF;

    typedef logic [MagW-1:0]        mag_t;
    typedef logic signed [ExpW-1:0] exp_t;
    typedef logic [6:0]             len_t;

    typedef struct packed {
        logic        exact;
        logic        special;
        logic [63:0] spec_hi;
        logic [63:0] spec_lo;
        exp_t        e2;
    } side_t;

    typedef struct packed {
        logic [63:0] value;
        logic        neg;
        mag_t        err;
    } rnd_t;

    // bit length of a product-wide magnitude
    function automatic len_t bit_len(mag_t v);
        len_t n;
        n = '0;
        for (int i = 0; i < MagW; i++)
        begin
            if (v[i])
            begin
                n = len_t'(i + 1);
            end
        end
        return n;
    endfunction

    // leading zeros of a 53-bit significand
    function automatic logic [5:0] lead_zeros(logic [52:0] v);
        logic [5:0] z;
        z = 6'd53;
        for (int i = 0; i < 53; i++)
        begin
            if (v[i])
            begin
                z = 6'(52 - i);
            end
        end
        return z;
    endfunction

    // round mag * 2^ex (bit length n, mag nonzero) to nearest even
    function automatic rnd_t round_pack(mag_t mag, len_t n, exp_t ex);
        rnd_t        r;
        exp_t        t;
        exp_t        p;
        exp_t        s;
        exp_t        ns;
        exp_t        ef;
        logic [6:0]  sh;
        logic [6:0]  hb;
        logic [MagW:0] ext;
        logic [MagW:0] mask;
        logic [MagW:0] rem;
        logic [MagW:0] err_w;
        mag_t        sig_w;
        logic [53:0] sig;
        logic        half;
        logic        sticky;
        logic        up;
        r   = '0;
        t   = ex + $signed({7'b0, n}) - exp_t'(1);
        p   = '0;
        s   = '0;
        ns  = '0;
        ef  = '0;
        sh  = '0;
        hb  = '0;
        ext = {1'b0, mag};
        mask = '0;
        rem  = '0;
        err_w = '0;
        sig_w = '0;
        sig  = '0;
        half = 1'b0;
        sticky = 1'b0;
        up   = 1'b0;
        if (t > exp_t'(1023))
        begin
            r.value = F64_INF;
        end
        else
        begin
            p = (t >= -exp_t'(1022)) ? exp_t'(53) : t + exp_t'(1075);
            if (p < 0)
            begin
                r.err = mag;
            end
            else
            begin
                s = $signed({7'b0, n}) - p;
                if (s <= exp_t'(0))
                begin
                    // magnitude fits the significand, nothing is rounded away
                    ns    = -s;
                    sh    = ns[6:0];
                    sig_w = mag << sh;
                    sig   = sig_w[53:0];
                end
                else
                begin
                    sh     = s[6:0];
                    hb     = sh - 7'd1;
                    mask   = ~({(MagW + 1){1'b1}} << sh);
                    rem    = ext & mask;
                    half   = ext[hb];
                    sticky = |(ext & (mask >> 1));
                    sig_w  = mag >> sh;
                    sig    = sig_w[53:0];
                    up     = half & (sticky | sig[0]);
                    err_w  = up ? ((mask + 1'b1) - rem) : rem;
                    r.err  = err_w[MagW-1:0];
                    r.neg  = up;
                    sig    = sig + {53'b0, up};
                end
                ef      = ex + s + exp_t'(1074);
                r.value = {1'b0, ef[10:0], 52'b0} + {10'b0, sig};
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/eds_in_if.sv
// ----------------------------------------------------------------------------
// eds_in_if
// operand channel: mode bit and binary64 operand
// ----------------------------------------------------------------------------
interface eds_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] x_bits;

    modport source (output valid, output action, output x_bits, input ready);
    modport sink   (input valid, input action, input x_bits, output ready);
endinterface

>>> hdl/eds_out_if.sv
// ----------------------------------------------------------------------------
// eds_out_if
// result channel: rounded square and its error term
// ----------------------------------------------------------------------------
interface eds_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hi_bits;
    logic [63:0] lo_bits;

    modport source (output valid, output hi_bits, output lo_bits, input ready);
    modport sink   (input valid, input hi_bits, input lo_bits, output ready);
endinterface

>>> hdl/exact_double_square_top.sv
// ----------------------------------------------------------------------------
// exact_double_square_top
// error-free square of a binary64 operand, seven-stage pipeline
// ----------------------------------------------------------------------------
// operand channel carries action and x_bits; result channel returns hi_bits
// (x*x rounded to nearest even) and lo_bits (the rounding error, rounded
// once, or +0 when action is 0). one result per operand, in order.
// throughput: one operand per cycle; the stages are input, normalize,
// partial products, product sum, hi rounding, error length, lo rounding.
// each stage moves on when the one after it is empty or moving, so
// bubbles close up and a stalled result only blocks once every stage
// behind it is full; operand ready then drops.
// reset clears all stage valid bits; no other register is reset.
// ----------------------------------------------------------------------------
`include "exact_double_square_top_macros.svh"

module exact_double_square_top
(
    input  logic clk,
    input  logic rst_n,
    eds_in_if.sink    operand,
    eds_out_if.source result
);
    import eds_pkg::*;

    logic [7:1] vld_reg;
    logic [7:1] adv;

    logic        act1_reg;
    logic [63:0] x1_reg;

    side_t       side2_reg, side2_next;
    logic [52:0] mn2_reg, mn2_next;
    side_t       side3_reg, side4_reg, side5_reg, side6_reg, side7_reg;

    mag_t        prod4;
    rnd_t        rnd5;
    logic [63:0] hi6_reg, hi7_reg;
    logic        neg6_reg, neg7_reg;
    mag_t        err6_reg;
    len_t        len6_reg;
    logic        nz7_reg;
    rnd_t        rnd7;
    logic [63:0] lo_out;

    // stage enables, back to front
    always_comb
    begin
        adv[7] = !vld_reg[7] || result.ready;
        for (int k = 6; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign operand.ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                vld_reg[1] <= operand.valid;
            end
            for (int k = 2; k <= 7; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: input register
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            act1_reg <= operand.action;
            x1_reg   <= operand.x_bits;
        end
    end

    // stage 2: classify and normalize
    always_comb
    begin
        logic [10:0] expo;
        logic [51:0] frac;
        logic [52:0] m;
        logic [5:0]  lz;
        logic [10:0] e;
        exp_t        eu;
        expo = x1_reg[62:52];
        frac = x1_reg[51:0];
        m    = (expo != 11'd0) ? {1'b1, frac} : {1'b0, frac};
        lz   = lead_zeros(m);
        e    = (expo != 11'd0) ? expo : 11'd1;
        eu   = $signed({3'b0, e}) - exp_t'(1075) - $signed({8'b0, lz});
        mn2_next = m << lz;
        side2_next.exact   = act1_reg;
        side2_next.e2      = eu <<< 1;
        side2_next.special = 1'b0;
        side2_next.spec_hi = F64_ZERO;
        side2_next.spec_lo = F64_ZERO;
        if (expo == EXP_MAX)
        begin
            side2_next.special = 1'b1;
            if (frac != 52'd0)
            begin
                side2_next.spec_hi = x1_reg | F64_QUIET;
                side2_next.spec_lo = act1_reg ? (x1_reg | F64_QUIET) : F64_ZERO;
            end
            else
            begin
                side2_next.spec_hi = F64_INF;
                side2_next.spec_lo = act1_reg ? F64_QNAN : F64_ZERO;
            end
        end
        else if (expo == 11'd0 && frac == 52'd0)
        begin
            side2_next.special = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            side2_reg <= side2_next;
            mn2_reg   <= mn2_next;
        end
        if (adv[3])
        begin
            side3_reg <= side2_reg;
        end
        if (adv[4])
        begin
            side4_reg <= side3_reg;
        end
        if (adv[5])
        begin
            side5_reg <= side4_reg;
        end
    end

    // stages 3 and 4: significand square
    eds_mul u_mul
    (
        .clk    (clk),
        .en_pp  (adv[3]),
        .en_sum (adv[4]),
        .m      (mn2_reg),
        .prod   (prod4)
    );

    // stage 5: round the square
    eds_round u_round_hi
    (
        .clk (clk),
        .en  (adv[5]),
        .mag (prod4),
        .len (prod4[MagW-1] ? len_t'(MagW) : len_t'(MagW - 1)),
        .ex  (side4_reg.e2),
        .res (rnd5)
    );

    // stage 6: length of the error term
    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            side6_reg <= side5_reg;
            hi6_reg   <= rnd5.value;
            neg6_reg  <= rnd5.neg;
            err6_reg  <= rnd5.err;
            len6_reg  <= bit_len(rnd5.err);
        end
    end

    // stage 7: round the error
    eds_round u_round_lo
    (
        .clk (clk),
        .en  (adv[7]),
        .mag (err6_reg),
        .len (len6_reg),
        .ex  (side6_reg.e2),
        .res (rnd7)
    );

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            side7_reg <= side6_reg;
            hi7_reg   <= hi6_reg;
            neg7_reg  <= neg6_reg;
            nz7_reg   <= (err6_reg != '0);
        end
    end

    always_comb
    begin
        if (side7_reg.special)
        begin
            lo_out = side7_reg.spec_lo;
        end
        else if (hi7_reg == F64_INF)
        begin
            lo_out = side7_reg.exact ? F64_NEG_INF : F64_ZERO;
        end
        else if (side7_reg.exact && nz7_reg)
        begin
            lo_out = {rnd7.value[63] | neg7_reg, rnd7.value[62:0]};
        end
        else
        begin
            lo_out = F64_ZERO;
        end
    end

    assign result.valid   = vld_reg[7];
    assign result.hi_bits = side7_reg.special ? side7_reg.spec_hi : hi7_reg;
    assign result.lo_bits = lo_out;

    `EDS_ASSERT_IMPL(a_naive_lo_zero, vld_reg[7] && !side7_reg.exact, result.lo_bits == F64_ZERO, "naive mode gave nonzero error term")
    `EDS_ASSERT_IMPL(a_hi_sign, vld_reg[7] && !side7_reg.special, !result.hi_bits[63], "square came out negative")
    `EDS_ASSERT_IMPL(a_roundup_err, vld_reg[6] && neg6_reg, err6_reg != '0, "round up with zero error")
    `EDS_ASSERT_NEXT(a_stall_keep, vld_reg[7] && !result.ready, vld_reg[7] && $stable(hi7_reg), "stalled result lost")
endmodule

>>> hdl/eds_mul.sv
// ----------------------------------------------------------------------------
// eds_mul
// two-stage 53x53 significand squarer: partial products, then sum
// ----------------------------------------------------------------------------
module eds_mul
(
    input  logic           clk,
    input  logic           en_pp,
    input  logic           en_sum,
    input  logic [52:0]    m,
    output eds_pkg::mag_t  prod
);
    import eds_pkg::*;

    logic [20:0] a;
    logic [31:0] b;
    logic [41:0] aa_reg;
    logic [52:0] ab_reg;
    logic [63:0] bb_reg;
    mag_t        prod_reg;
    mag_t        prod_next;

    assign a = m[52:32];
    assign b = m[31:0];

    always_ff @(posedge clk)
    begin
        if (en_pp)
        begin
            aa_reg <= a * a;
            ab_reg <= {21'b0, a} * {21'b0, b};
            bb_reg <= b * b;
        end
    end

    // m^2 = aa*2^64 + 2*ab*2^32 + bb
    assign prod_next = {aa_reg, 64'b0} + {20'b0, ab_reg, 33'b0} + {42'b0, bb_reg};

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;
endmodule

>>> hdl/eds_round.sv
// ----------------------------------------------------------------------------
// eds_round
// registered round-to-nearest-even of a wide magnitude to binary64
// ----------------------------------------------------------------------------
module eds_round
(
    input  logic           clk,
    input  logic           en,
    input  eds_pkg::mag_t  mag,
    input  eds_pkg::len_t  len,
    input  eds_pkg::exp_t  ex,
    output eds_pkg::rnd_t  res
);
    import eds_pkg::*;

    rnd_t res_reg;
    rnd_t res_next;

    assign res_next = round_pack(mag, len, ex);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;
endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the exact binary64 square pipeline
// ----------------------------------------------------------------------------
// a directed table covers zeros, extremes, specials, overflow and underflow,
// then random operands, mostly finite, in both modes. every result is
// compared against an integer model of the rounded square and its error.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import eds_pkg::*;

    localparam int    WatchLimit = 20000;
    localparam int    RandItems  = 750;
    localparam logic [63:0] NoCheck = 64'hDEAD_BEEF_DEAD_BEEF;

    typedef struct packed {
        logic        action;
        logic [63:0] x;
        logic [63:0] hi;
        logic [63:0] lo;
    } row_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } square_t;

    logic clk;
    logic rst_n;
    int   fails;
    int   idle_cycles;
    int   send_gap;
    int   recv_gap;
    logic long_hold;
    square_t squares_due[$];

    eds_in_if  operand();
    eds_out_if result();

    exact_double_square_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand.sink),
        .result  (result.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // round a nonzero magnitude m * 2^ex to binary64, report error
    function automatic logic [63:0] to_f64(logic [127:0] m, int ex, output logic up,
                                           output logic [127:0] err);
        int          n;
        int          t;
        int          p;
        int          s;
        logic [127:0] rem;
        logic [63:0] sig;
        logic        half;
        logic        sticky;
        n = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (m[i])
            begin
                n = i + 1;
            end
        end
        up  = 1'b0;
        err = '0;
        t   = ex + n - 1;
        if (t > 1023)
        begin
            return F64_INF;
        end
        p = (t >= -1022) ? 53 : t + 1075;
        if (p < 0)
        begin
            err = m;
            return F64_ZERO;
        end
        s = n - p;
        if (s <= 0)
        begin
            sig = m[63:0] << (-s);
        end
        else
        begin
            sig    = 64'(m >> s);
            rem    = m & ~({128{1'b1}} << s);
            half   = m[s - 1];
            sticky = (s > 1) && ((rem & ~({128{1'b1}} << (s - 1))) != 0);
            if (half && (sticky || sig[0]))
            begin
                up  = 1'b1;
                sig = sig + 1;
                err = (128'd1 << s) - rem;
            end
            else
            begin
                err = rem;
            end
        end
        return (64'(ex + s + 1074) << 52) + sig;
    endfunction

    function automatic square_t square_of(logic action, logic [63:0] x);
        square_t      r;
        logic [10:0]  ex;
        logic [51:0]  fr;
        logic [52:0]  m;
        logic [127:0] prod;
        logic [127:0] err;
        logic [127:0] err2;
        logic         up;
        logic         up2;
        int           e2;
        ex = x[62:52];
        fr = x[51:0];
        r  = '0;
        if (ex == EXP_MAX)
        begin
            if (fr != 0)
            begin
                r.hi = x | F64_QUIET;
                r.lo = action ? r.hi : F64_ZERO;
            end
            else
            begin
                r.hi = F64_INF;
                r.lo = action ? F64_QNAN : F64_ZERO;
            end
        end
        else if (ex != 0 || fr != 0)
        begin
            m    = (ex != 0) ? {1'b1, fr} : {1'b0, fr};
            e2   = 2 * ((ex != 0) ? int'(ex) - 1075 : -1074);
            prod = 128'(m) * 128'(m);
            r.hi = to_f64(prod, e2, up, err);
            if (r.hi == F64_INF)
            begin
                r.lo = action ? F64_NEG_INF : F64_ZERO;
            end
            else if (action && err != 0)
            begin
                r.lo = to_f64(err, e2, up2, err2);
                r.lo[63] = up;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_f64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v[62:52] = 11'($urandom_range(0, 2));
            1: v[62:52] = 11'($urandom_range(1530, 1540));
            2: v[62:52] = 11'($urandom_range(500, 560));
            3: v[62:52] = EXP_MAX;
            4: v[51:0]  = {26'($urandom), 26'h0};
            default: v[62:52] = 11'($urandom_range(600, 1500));
        endcase
        return v;
    endfunction

    task automatic send(logic action, logic [63:0] x, logic [63:0] hi, logic [63:0] lo);
        square_t want;
        while (send_gap > 0 && $urandom_range(0, 99) < send_gap)
        begin
            operand.valid <= 1'b0;
            @(posedge clk);
        end
        want = square_of(action, x);
        if (hi != NoCheck && (want.hi != hi || want.lo != lo))
        begin
            $error("table row x=%h: hi %h/%h lo %h/%h", x, hi, want.hi, lo, want.lo);
            fails++;
        end
        operand.valid  <= 1'b1;
        operand.action <= action;
        operand.x_bits <= x;
        @(posedge clk);
        while (!operand.ready)
        begin
            @(posedge clk);
        end
        squares_due.push_back(want);
    endtask

    // sender: directed table, then random phases
    initial
    begin
        row_t table_rows[$];
        table_rows = '{
            '{1'b1, 64'h0000000000000000, F64_ZERO, F64_ZERO},
            '{1'b1, 64'h8000000000000000, F64_ZERO, F64_ZERO},
            '{1'b0, 64'h3FF0000000000000, 64'h3FF0000000000000, F64_ZERO},
            '{1'b1, 64'hBFF0000000000000, 64'h3FF0000000000000, F64_ZERO},
            '{1'b1, 64'h7FF0000000000000, F64_INF, F64_QNAN},
            '{1'b0, 64'hFFF0000000000000, F64_INF, F64_ZERO},
            '{1'b1, 64'h7FF0000000000001, 64'h7FF8000000000001, 64'h7FF8000000000001},
            '{1'b0, 64'hFFF4000000000000, 64'hFFFC000000000000, F64_ZERO},
            '{1'b1, 64'h7FEFFFFFFFFFFFFF, F64_INF, F64_NEG_INF},
            '{1'b0, 64'h7FEFFFFFFFFFFFFF, F64_INF, F64_ZERO},
            '{1'b1, 64'h0000000000000001, F64_ZERO, F64_ZERO},
            '{1'b1, 64'h000FFFFFFFFFFFFF, NoCheck, NoCheck},
            '{1'b1, 64'h0010000000000000, NoCheck, NoCheck},
            '{1'b1, 64'h1FF0000000000001, NoCheck, NoCheck},
            '{1'b1, 64'h3FF0000000000001, NoCheck, NoCheck},
            '{1'b1, 64'h3FFFFFFFFFFFFFFF, NoCheck, NoCheck},
            '{1'b0, 64'h3FFFFFFFFFFFFFFF, NoCheck, NoCheck},
            '{1'b1, 64'h5FEFFFFFFFFFFFFF, NoCheck, NoCheck},
            '{1'b1, 64'h5FF0000000000000, NoCheck, NoCheck},
            '{1'b1, 64'h1FFFFFFFFFFFFFFF, NoCheck, NoCheck},
            '{1'b1, 64'hBFF5555555555555, NoCheck, NoCheck}
        };
        operand.valid  <= 1'b0;
        operand.action <= 1'b0;
        operand.x_bits <= '0;
        send_gap = 0;
        recv_gap = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
        begin
            send(table_rows[i].action, table_rows[i].x, table_rows[i].hi, table_rows[i].lo);
        end
        // receiver stalls long while operands keep coming
        long_hold = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            send($urandom_range(0, 1), rand_f64(), NoCheck, NoCheck);
        end
        // sender waits for the pipe to drain
        operand.valid <= 1'b0;
        while (squares_due.size() != 0)
        begin
            @(posedge clk);
        end
        for (int ph = 0; ph < 3; ph++)
        begin
            send_gap = (ph == 0) ? 14 : (ph == 1) ? 73 : 0;
            recv_gap = (ph == 0) ? 73 : (ph == 1) ? 14 : 0;
            for (int i = 0; i < RandItems / 3; i++)
            begin
                send($urandom_range(0, 1), rand_f64(), NoCheck, NoCheck);
            end
        end
        operand.valid <= 1'b0;
        while (squares_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fails == 0)
        begin
            $display("** exact_double_square_top: PASSED **");
        end
        else
        begin
            $display("** exact_double_square_top: FAILED **");
        end
        $finish;
    end

    // receiver ready, with one long hold-off
    initial
    begin
        result.ready <= 1'b0;
        @(posedge clk);
        while (!long_hold)
        begin
            result.ready <= 1'b1;
            @(posedge clk);
        end
        result.ready <= 1'b0;
        repeat (60) @(posedge clk);
        forever
        begin
            result.ready <= !(recv_gap > 0 && $urandom_range(0, 99) < recv_gap);
            @(posedge clk);
        end
    end

    // result checker and watchdog
    initial
    begin
        fails = 0;
        idle_cycles = 0;
    end

    always @(posedge clk)
    begin
        square_t want;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (squares_due.size() == 0)
                begin
                    $error("result transfer with nothing outstanding");
                    fails++;
                end
                else
                begin
                    want = squares_due.pop_front();
                    if (result.hi_bits !== want.hi)
                    begin
                        $error("hi_bits expected %h actual %h", want.hi, result.hi_bits);
                        fails++;
                    end
                    if (result.lo_bits !== want.lo)
                    begin
                        $error("lo_bits expected %h actual %h", want.lo, result.lo_bits);
                        fails++;
                    end
                end
            end
            if ((operand.valid && operand.ready) || (result.valid && result.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WatchLimit)
                begin
                    $display("** exact_double_square_top: FAILED **");
                    $finish;
                end
            end
        end
    end
endmodule
